// ----- rtl/smli_pkg.sv -----
// Package for the sorted match list: entry layout, status and mode codes,
// register map constants. No dependencies.
package smli_pkg;

   localparam int LIST_DEPTH_DEF = 64;

   localparam int MODE_W   = 2;
   localparam int POS_W    = 16;
   localparam int LEN_W    = 16;
   localparam int WORD_W   = 32;
   localparam int INDEX_W  = 6;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 6;
   localparam int COUNT_W  = 7;
   localparam int MAXAL_W  = 7;

   localparam int                  ADDR_W         = 3;
   localparam int                  DATA_W         = 32;
   localparam logic [ADDR_W-1:0]   CSR_MAX_ALIGN  = 3'h0;
   localparam logic [MAXAL_W-1:0]  MAX_ALIGN_RST  = 7'd64;

   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_NOP    = 2'd3;

   localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_READ      = 3'd4;

   typedef struct packed {
      logic [POS_W-1:0]  read_pos;
      logic [LEN_W-1:0]  match_length;
      logic              direction;
      logic [WORD_W-1:0] sa_left;
      logic [WORD_W-1:0] sa_right;
      logic [WORD_W-1:0] repeats;
   } entry_type;

endpackage

// ----- rtl/sorted_match_list_insert.sv -----
// Sorted match list top level: sequencer around one entry memory and one
// shared 32-bit key comparator. Depends on smli_pkg.
// Insert: accept, scan of up to (place+1) entries through the registered read port,
//   then (count-place) moves at one per cycle.
// One item at a time; a result waits in the output register while the next
//   item is accepted.
// Reset (synchronous): count 0, capacity 64; list memory is not cleared and
//   needs no clearing pass, since entries at or above count never reach the output.
module sorted_match_list_insert #(
   parameter int LIST_DEPTH = smli_pkg::LIST_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [smli_pkg::MODE_W-1:0]       req_mode,
   input  logic [smli_pkg::POS_W-1:0]        req_read_pos,
   input  logic [smli_pkg::LEN_W-1:0]        req_match_length,
   input  logic                              req_direction,
   input  logic [smli_pkg::WORD_W-1:0]       req_sa_left,
   input  logic [smli_pkg::WORD_W-1:0]       req_sa_right,
   input  logic [smli_pkg::WORD_W-1:0]       req_repeat_count,
   input  logic [smli_pkg::INDEX_W-1:0]      req_index,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [smli_pkg::STATUS_W-1:0]     rsp_status,
   output logic [smli_pkg::SLOT_W-1:0]       rsp_slot,
   output logic [smli_pkg::COUNT_W-1:0]      rsp_count,
   output logic [smli_pkg::POS_W-1:0]        rsp_out_read_pos,
   output logic [smli_pkg::LEN_W-1:0]        rsp_out_length,
   output logic                              rsp_out_direction,
   output logic [smli_pkg::WORD_W-1:0]       rsp_out_sa_left,
   output logic [smli_pkg::WORD_W-1:0]       rsp_out_sa_right,
   output logic [smli_pkg::WORD_W-1:0]       rsp_out_repeat,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [smli_pkg::ADDR_W-1:0]       paddr,
   input  logic [smli_pkg::DATA_W-1:0]       pwdata,
   output logic [smli_pkg::DATA_W-1:0]       prdata,
   output logic                              pready
);
   import smli_pkg::*;

   localparam int IDX_W = $clog2(LIST_DEPTH);
   localparam int CNT_W = $clog2(LIST_DEPTH + 1);
   localparam int CMP_W = (CNT_W > MAXAL_W) ? CNT_W : MAXAL_W;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_SCAN     = 3'd1;
   localparam logic [2:0] S_SHIFT    = 3'd2;
   localparam logic [2:0] S_REPLY    = 3'd3;
   localparam logic [2:0] S_READ     = 3'd4;
   localparam logic [2:0] S_READ_OUT = 3'd5;

   // list storage
   entry_type        entry_mem [LIST_DEPTH];
   entry_type        rd_data_ff;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;

   logic [2:0]         state_ff, state_in;
   logic [CNT_W-1:0]   ptr_ff, ptr_in;
   logic [CNT_W-1:0]   place_ff, place_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               pipe_vld_ff, pipe_vld_in;
   logic [CNT_W-1:0]   pipe_idx_ff, pipe_idx_in;
   logic [STATUS_W-1:0] reply_ff, reply_in;
   logic [MAXAL_W-1:0] max_ff, max_in;

   entry_type          hold_ff;
   logic [INDEX_W-1:0] hold_index_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;
   entry_type           rsp_entry_ff;

   logic                res_load;
   logic [STATUS_W-1:0] res_status;
   logic [SLOT_W-1:0]   res_slot;
   logic [CNT_W-1:0]    res_count;
   entry_type           res_entry;

   logic accept;
   logic out_free;
   logic list_full;
   logic key_gt;
   logic key_eq;
   logic csr_write;
   logic csr_hit;

   assign accept    = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign list_full = (CMP_W'(cnt_ff) >= CMP_W'(max_ff)) || (cnt_ff >= CNT_W'(LIST_DEPTH));

   // shared comparator: stored (pos, length) against the incoming hit
   assign key_gt = {rd_data_ff.read_pos, rd_data_ff.match_length} >
                   {hold_ff.read_pos, hold_ff.match_length};
   assign key_eq = {rd_data_ff.read_pos, rd_data_ff.match_length} ==
                   {hold_ff.read_pos, hold_ff.match_length};

   always_comb begin
      state_in    = state_ff;
      ptr_in      = ptr_ff;
      place_in    = place_ff;
      cnt_in      = cnt_ff;
      reply_in    = reply_ff;
      pipe_vld_in = 1'b0;
      pipe_idx_in = pipe_idx_ff;
      rd_en       = 1'b0;
      rd_addr     = ptr_ff[IDX_W-1:0];
      wr_en       = 1'b0;
      wr_addr     = place_ff[IDX_W-1:0];
      wr_data     = hold_ff;
      res_load    = 1'b0;
      res_status  = ST_INSERTED;
      res_slot    = SLOT_W'(place_ff);
      res_count   = cnt_ff;
      res_entry   = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_mode)
                  MODE_INSERT: begin
                     ptr_in = '0;
                     if (list_full) begin
                        reply_in = ST_FULL;
                        place_in = '0;
                        state_in = S_REPLY;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  MODE_CLEAR: begin
                     reply_in = ST_CLEARED;
                     place_in = '0;
                     state_in = S_REPLY;
                  end
                  MODE_READ: state_in = S_READ;
                  MODE_NOP:  state_in = S_IDLE;
                  default:   state_in = S_IDLE;
               endcase
            end
         end

         S_SCAN: begin
            // read issued in the cycle before its compare
            if (pipe_vld_ff && (key_gt || (key_eq && rd_data_ff.direction == hold_ff.direction)))
            begin
               place_in = pipe_idx_ff;
               ptr_in   = cnt_ff;
               if (key_eq) begin
                  reply_in = ST_DUPLICATE;
                  state_in = S_REPLY;
               end else begin
                  state_in = S_SHIFT;
               end
            end else if (!pipe_vld_ff && ptr_ff >= cnt_ff) begin
               place_in = cnt_ff;
               ptr_in   = cnt_ff;
               state_in = S_SHIFT;
            end else if (ptr_ff < cnt_ff) begin
               rd_en       = 1'b1;
               rd_addr     = ptr_ff[IDX_W-1:0];
               pipe_vld_in = 1'b1;
               pipe_idx_in = ptr_ff;
               ptr_in      = ptr_ff + CNT_W'(1);
            end
         end

         S_SHIFT: begin
            // move entries up one slot, top first; pipe_idx holds the target
            if (pipe_vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = pipe_idx_ff[IDX_W-1:0];
               wr_data = rd_data_ff;
            end
            if (ptr_ff > place_ff) begin
               rd_en       = 1'b1;
               rd_addr     = IDX_W'(ptr_ff - CNT_W'(1));
               pipe_vld_in = 1'b1;
               pipe_idx_in = ptr_ff;
               ptr_in      = ptr_ff - CNT_W'(1);
            end else if (!pipe_vld_ff && out_free) begin
               wr_en      = 1'b1;
               wr_addr    = place_ff[IDX_W-1:0];
               wr_data    = hold_ff;
               cnt_in     = cnt_ff + CNT_W'(1);
               res_load   = 1'b1;
               res_status = ST_INSERTED;
               res_count  = cnt_ff + CNT_W'(1);
               state_in   = S_IDLE;
            end
         end

         S_REPLY: begin
            if (out_free) begin
               res_load   = 1'b1;
               res_status = reply_ff;
               if (reply_ff == ST_CLEARED) begin
                  cnt_in    = '0;
                  res_count = '0;
               end
               state_in = S_IDLE;
            end
         end

         S_READ: begin
            rd_en    = 1'b1;
            rd_addr  = IDX_W'(hold_index_ff);
            state_in = S_READ_OUT;
         end

         S_READ_OUT: begin
            if (out_free) begin
               res_load   = 1'b1;
               res_status = ST_READ;
               res_slot   = hold_index_ff;
               if (CMP_W'(hold_index_ff) < CMP_W'(cnt_ff)) begin
                  res_entry = rd_data_ff;
               end
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = res_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   // configuration port
   assign pready    = 1'b1;
   assign csr_hit   = (paddr[ADDR_W-1:2] == CSR_MAX_ALIGN[ADDR_W-1:2]);
   assign csr_write = psel && penable && pwrite && pready && csr_hit;
   assign max_in    = csr_write ? pwdata[MAXAL_W-1:0] : max_ff;
   assign prdata    = (psel && csr_hit) ? DATA_W'(max_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ptr_ff       <= '0;
         place_ff     <= '0;
         cnt_ff       <= '0;
         pipe_vld_ff  <= 1'b0;
         pipe_idx_ff  <= '0;
         reply_ff     <= ST_INSERTED;
         max_ff       <= MAX_ALIGN_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         place_ff     <= place_in;
         cnt_ff       <= cnt_in;
         pipe_vld_ff  <= pipe_vld_in;
         pipe_idx_ff  <= pipe_idx_in;
         reply_ff     <= reply_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_ff.read_pos     <= req_read_pos;
         hold_ff.match_length <= req_match_length;
         hold_ff.direction    <= req_direction;
         hold_ff.sa_left      <= req_sa_left;
         hold_ff.sa_right     <= req_sa_right;
         hold_ff.repeats      <= req_repeat_count;
         hold_index_ff        <= req_index;
      end
      if (res_load) begin
         rsp_status_ff <= res_status;
         rsp_slot_ff   <= res_slot;
         rsp_count_ff  <= COUNT_W'(res_count);
         rsp_entry_ff  <= res_entry;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_slot          = rsp_slot_ff;
   assign rsp_count         = rsp_count_ff;
   assign rsp_out_read_pos  = rsp_entry_ff.read_pos;
   assign rsp_out_length    = rsp_entry_ff.match_length;
   assign rsp_out_direction = rsp_entry_ff.direction;
   assign rsp_out_sa_left   = rsp_entry_ff.sa_left;
   assign rsp_out_sa_right  = rsp_entry_ff.sa_right;
   assign rsp_out_repeat    = rsp_entry_ff.repeats;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(LIST_DEPTH))
      else $error("entry count above list depth");

   a_cnt_grow: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != $past(cnt_ff)) && (cnt_ff != '0) |->
         (cnt_ff == $past(cnt_ff) + CNT_W'(1)) && rsp_valid_ff &&
         (rsp_status_ff == ST_INSERTED))
      else $error("count grew without an insert beat");

   a_scan_ptr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (ptr_ff <= cnt_ff))
      else $error("scan pointer ran past the list");

   a_shift_ptr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |-> (ptr_ff >= place_ff) && (place_ff <= cnt_ff) &&
         (cnt_ff < CNT_W'(LIST_DEPTH)))
      else $error("shift pointer below insert place or list full");

endmodule
